FILE: design/bins_pkg.sv
package bins_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_STRIDE  = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_RATIO_X = 2'd2;
  localparam logic [1:0] REG_RATIO_Y = 2'd3;

  localparam int CFG_W    = 24;
  localparam int STRIDE_W = 12;
  localparam int ROWS_W   = 15;
  localparam int RATIO_W  = 24;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 15;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Q8.16 ratios: source coordinate is product bits above the fraction
  localparam int FRAC_W  = 16;
  localparam int COORD_W = 19;
  localparam int BASE_W  = ROWS_W + STRIDE_W;
  localparam int SADDR_W = BASE_W + 1;

  localparam logic [2:0] PIX_MSB = 3'd7;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [13:0] store_address;
    logic [7:0]  store_byte;
    logic [7:0]  dst_column_byte;
    logic [10:0] dst_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       out_of_range;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: design/bins_mul.sv
module bins_mul (
  input  logic                          clk,
  input  logic [bins_pkg::MUL_A_W-1:0]  a,
  input  logic [bins_pkg::MUL_B_W-1:0]  b,
  output logic [bins_pkg::MUL_P_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= bins_pkg::MUL_P_W'(a) * bins_pkg::MUL_P_W'(b);
  end

endmodule

FILE: design/bins_store.sv
module bins_store #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                 clk,
  input  bins_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]        addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);

  logic [7:0] mem [DEPTH];

  // single port: write and read never share a cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: design/binary_image_nearest_scaler.sv
// write transaction: stored at acceptance, no result, ready again next cycle
// read transaction: no new item is accepted until its result is loaded, which waits while
//   an earlier result is untaken; it takes eight pixel products through the one shared
//   multiplier and eight reads of the single-port source store, pipelined by two stages
// read of a destination row outside the source: no pixel reads, result flagged out of range
// synchronous reset restores the register defaults; source store is not cleared
module binary_image_nearest_scaler #(
  parameter int STORE_BYTES  = 16384,
  parameter int MAX_DST_ROWS = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bins_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bins_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bins_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW = $clog2(STORE_BYTES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROW   = 5'b00010,
    S_BASE  = 5'b00100,
    S_PIX   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state;

  logic [bins_pkg::STRIDE_W-1:0] stride;
  logic [bins_pkg::ROWS_W-1:0]   rows;
  logic [bins_pkg::RATIO_W-1:0]  ratio_x;
  logic [bins_pkg::RATIO_W-1:0]  ratio_y;

  logic [7:0]  col_q;
  logic [10:0] row_q;
  logic [2:0]  cnt;
  logic [bins_pkg::BASE_W-1:0] base;
  logic [7:0]  pix;
  logic        flag;

  logic        s1_valid;
  logic [2:0]  s1_idx;
  logic        s2_valid;
  logic [2:0]  s2_idx;
  logic [2:0]  s2_bit;
  logic        s2_bad;

  logic [bins_pkg::MUL_A_W-1:0] mul_a;
  logic [bins_pkg::MUL_B_W-1:0] mul_b;
  logic [bins_pkg::MUL_P_W-1:0] prod;

  logic [bins_pkg::COORD_W-1:0] coord;
  logic [bins_pkg::COORD_W-1:0] width;
  logic [bins_pkg::SADDR_W-1:0] src_addr;
  logic                         s1_bad;
  logic                         row_bad;

  bins_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [7:0]         rd_data;

  logic in_acc;
  logic wr_ok;
  logic load_out;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      stride  <= bins_pkg::STRIDE_W'(1);
      rows    <= bins_pkg::ROWS_W'(1);
      ratio_x <= bins_pkg::RATIO_W'(65536);
      ratio_y <= bins_pkg::RATIO_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bins_pkg::REG_STRIDE:  stride  <= cfg_data[bins_pkg::STRIDE_W-1:0];
        bins_pkg::REG_ROWS:    rows    <= cfg_data[bins_pkg::ROWS_W-1:0];
        bins_pkg::REG_RATIO_X: ratio_x <= cfg_data[bins_pkg::RATIO_W-1:0];
        bins_pkg::REG_RATIO_Y: ratio_y <= cfg_data[bins_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_ok    = 32'(in_data.store_address) < 32'(STORE_BYTES);
  assign load_out = (state == S_DRAIN) && !s1_valid && !s2_valid && (!out_valid || out_ready);

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_ROW: begin
        mul_a = bins_pkg::MUL_A_W'(row_q);
        mul_b = ratio_y;
      end
      S_BASE: begin
        mul_a = coord[bins_pkg::MUL_A_W-1:0];
        mul_b = bins_pkg::MUL_B_W'(stride);
      end
      S_PIX: begin
        mul_a = bins_pkg::MUL_A_W'({col_q, cnt});
        mul_b = ratio_x;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bins_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // source coordinate from the last product, row in S_BASE, column in stage 1
  assign coord    = prod[bins_pkg::FRAC_W +: bins_pkg::COORD_W];
  assign width    = bins_pkg::COORD_W'({stride, 3'b000});
  assign row_bad  = (32'(row_q) >= 32'(MAX_DST_ROWS)) ||
                    (coord >= bins_pkg::COORD_W'(rows));
  assign src_addr = bins_pkg::SADDR_W'(base) + bins_pkg::SADDR_W'(coord[bins_pkg::COORD_W-1:3]);
  assign s1_bad   = (coord >= width) || (32'(src_addr) >= 32'(STORE_BYTES));

  assign mem_ctl.wr_en = in_acc && (in_data.operation == bins_pkg::OP_WRITE) && wr_ok;
  assign mem_ctl.rd_en = s1_valid;
  assign mem_addr      = mem_ctl.wr_en ? AW'(in_data.store_address) : src_addr[AW-1:0];

  bins_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (in_data.store_byte),
    .rdata (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_PIX);
      s2_valid <= s1_valid;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_data.operation == bins_pkg::OP_READ)) begin
            state <= S_ROW;
          end
        end
        S_ROW: begin
          state <= S_BASE;
        end
        S_BASE: begin
          cnt   <= '0;
          state <= row_bad ? S_DRAIN : S_PIX;
        end
        S_PIX: begin
          cnt <= cnt + 3'd1;
          if (cnt == bins_pkg::PIX_MSB) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_q <= in_data.dst_column_byte;
      row_q <= in_data.dst_row;
      pix   <= '0;
      flag  <= 1'b0;
    end
    if (state == S_BASE && row_bad) begin
      flag <= 1'b1;
    end
    // first pixel cycle still holds the row base product
    if (state == S_PIX && cnt == 3'd0) begin
      base <= prod[bins_pkg::BASE_W-1:0];
    end
    s2_idx <= s1_idx;
    s1_idx <= cnt;
    s2_bit <= coord[2:0];
    s2_bad <= s1_bad;
    if (s2_valid) begin
      if (s2_bad) begin
        flag <= 1'b1;
      end else begin
        pix[bins_pkg::PIX_MSB - s2_idx] <= rd_data[bins_pkg::PIX_MSB - s2_bit];
      end
    end
    if (load_out) begin
      out_data.pixel_byte   <= pix;
      out_data.out_of_range <= flag;
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!s1_valid && !s2_valid))
    else $error("pixel pipeline busy while accepting");

  a_result_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DRAIN))
    else $error("result loaded outside drain");

  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(s1_valid))
    else $error("stage 2 without stage 1");

  a_no_store_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.wr_en && mem_ctl.rd_en))
    else $error("store write and read in one cycle");

endmodule

FILE: tb/sv/scaled_pixel_checker.sv
`timescale 1ns / 100ps

module scaled_pixel_checker
  import bins_pkg::*;
#(
  parameter int STORE_BYTES = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               failures,
  output int               pending
);

  bit [7:0]          source_copy [STORE_BYTES];
  bit [STRIDE_W-1:0] stride;
  bit [ROWS_W-1:0]   rows;
  bit [RATIO_W-1:0]  ratio_x;
  bit [RATIO_W-1:0]  ratio_y;
  out_item_t         expected_pixels [$];
  int                mismatches;
  int                results_seen;

  function automatic out_item_t scale_byte(input logic [7:0] col, input logic [10:0] row);
    out_item_t        res;
    bit [MUL_P_W-1:0] prod;
    bit [COORD_W-1:0] sy;
    bit [COORD_W-1:0] sx;
    bit [32:0]        addr;
    res = '0;
    prod = row * ratio_y;
    sy = prod[FRAC_W +: COORD_W];
    if (sy >= rows) begin
      res.out_of_range = 1'b1;
      return res;
    end
    for (int i = 0; i < 8; i++) begin
      prod = {col, 3'(i)} * ratio_x;
      sx = prod[FRAC_W +: COORD_W];
      if (sx >= {stride, 3'b000}) begin
        res.out_of_range = 1'b1;
        continue;
      end
      addr = sy * stride + (sx >> 3);
      if (addr >= STORE_BYTES) begin
        res.out_of_range = 1'b1;
        continue;
      end
      if (source_copy[addr][PIX_MSB - sx[2:0]])
        res.pixel_byte[PIX_MSB - 3'(i)] = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      stride  = 1;
      rows    = 1;
      ratio_x = 24'h010000;
      ratio_y = 24'h010000;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STRIDE:  stride  = cfg_data[STRIDE_W-1:0];
          REG_ROWS:    rows    = cfg_data[ROWS_W-1:0];
          REG_RATIO_X: ratio_x = cfg_data[RATIO_W-1:0];
          REG_RATIO_Y: ratio_y = cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_READ)
          expected_pixels.push_back(scale_byte(in_data.dst_column_byte, in_data.dst_row));
        else
          source_copy[in_data.store_address] = in_data.store_byte;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: none expected, got pixel_byte %02h out_of_range %0b",
                     results_seen, out_data.pixel_byte, out_data.out_of_range);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_byte !== want.pixel_byte ||
              out_data.out_of_range !== want.out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected pixel_byte %02h out_of_range %0b, got %02h %0b",
                       results_seen, want.pixel_byte, want.out_of_range,
                       out_data.pixel_byte, out_data.out_of_range);
          end
        end
      end
    end
    pending  <= expected_pixels.size();
    failures <= mismatches;
  end

endmodule

FILE: tb/sv/binary_image_nearest_scaler_test.sv
`timescale 1ns / 100ps

module binary_image_nearest_scaler_test;
  import bins_pkg::*;

  localparam int STORE_BYTES   = 16384;
  localparam int MAX_DST_ROWS  = 2048;
  localparam int ITEM_GOAL     = 1650;
  localparam int PHASES        = 9;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 1000000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               failures;
  int               pending;

  bit                tx_gaps;
  bit                rx_stalls;
  int                rx_hold;
  int                rx_roll;
  bit                written [STORE_BYTES];
  bit [STRIDE_W-1:0] cur_stride = 1;
  bit [ROWS_W-1:0]   cur_rows   = 1;
  bit [RATIO_W-1:0]  cur_rx     = 24'h010000;
  bit [RATIO_W-1:0]  cur_ry     = 24'h010000;
  int                items_sent;
  int                reads_sent;
  int                settings_used;

  bit [STRIDE_W-1:0] fixed_stride [6] = '{1, 4, 16, 2048, 128, 0};
  bit [ROWS_W-1:0]   fixed_rows   [6] = '{1, 8, 32, 16384, 128, 0};
  bit [RATIO_W-1:0]  fixed_rx     [6] = '{24'h010000, 24'h008000, 24'h028000,
                                         24'h010000, 24'hFFFFFF, 24'h000000};
  bit [RATIO_W-1:0]  fixed_ry     [6] = '{24'h010000, 24'h008000, 24'h018000,
                                         24'h010000, 24'hFFFFFF, 24'h000000};

  binary_image_nearest_scaler #(
    .STORE_BYTES  (STORE_BYTES),
    .MAX_DST_ROWS (MAX_DST_ROWS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scaled_pixel_checker #(
    .STORE_BYTES (STORE_BYTES)
  ) watch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // result side: long stalls are rare, most holds are short
  always @(posedge clk) begin
    if (!rx_stalls) begin
      out_ready <= 1'b1;
      rx_hold   <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      out_ready <= (rx_roll >= 35);
      rx_hold   <= (rx_roll < 4) ? $urandom_range(15, 60) : $urandom_range(0, 3);
    end
  end

  function automatic int tx_gap();
    int roll;
    if (!tx_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // source bytes a read will touch, so none is read before it was written
  function automatic void source_bytes_read(input bit [7:0] col, input bit [10:0] row,
                                            ref int unsigned addrs[$]);
    bit [MUL_P_W-1:0] prod;
    bit [COORD_W-1:0] sy;
    bit [COORD_W-1:0] sx;
    bit [32:0]        addr;
    addrs = {};
    prod = row * cur_ry;
    sy = prod[FRAC_W +: COORD_W];
    if (sy >= cur_rows) return;
    for (int i = 0; i < 8; i++) begin
      prod = {col, 3'(i)} * cur_rx;
      sx = prod[FRAC_W +: COORD_W];
      if (sx >= {cur_stride, 3'b000}) continue;
      addr = sy * cur_stride + (sx >> 3);
      if (addr < STORE_BYTES) addrs.push_back(int'(addr));
    end
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_byte(input int unsigned addr, input bit [7:0] data);
    in_item_t    item;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    item = noise[$bits(in_item_t)-1:0];
    item.operation     = OP_WRITE;
    item.store_address = addr[13:0];
    item.store_byte    = data;
    send_item(item);
    written[addr] = 1'b1;
  endtask

  task automatic read_pixels(input bit [7:0] col, input bit [10:0] row);
    int unsigned addrs [$];
    in_item_t    item;
    logic [63:0] noise;
    source_bytes_read(col, row, addrs);
    foreach (addrs[k])
      if (!written[addrs[k]]) write_byte(addrs[k], 8'($urandom_range(0, 255)));
    noise = {$urandom, $urandom};
    item = noise[$bits(in_item_t)-1:0];
    item.operation       = OP_READ;
    item.dst_column_byte = col;
    item.dst_row         = row;
    send_item(item);
    reads_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input bit [STRIDE_W-1:0] stride, input bit [ROWS_W-1:0] rows,
                                input bit [RATIO_W-1:0] rx, input bit [RATIO_W-1:0] ry);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_STRIDE;
    cfg_data  <= CFG_W'(stride);
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data  <= CFG_W'(rows);
    @(posedge clk);
    cfg_index <= REG_RATIO_X;
    cfg_data  <= rx;
    @(posedge clk);
    cfg_index <= REG_RATIO_Y;
    cfg_data  <= ry;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_stride = stride;
    cur_rows   = rows;
    cur_rx     = rx;
    cur_ry     = ry;
    settings_used++;
  endtask

  initial begin : stimulus
    int      budget;
    int      start;
    int      roll;
    bit      paused;
    longint  row_lim;
    longint  col_lim;
    bit [7:0]  col;
    bit [10:0] row;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_STRIDE;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: source is a single 8-pixel row
    write_byte(0, 8'hA5);
    read_pixels(0, 0);
    read_pixels(1, 0);          // columns past the source width
    read_pixels(0, 1);          // row past the source height
    read_pixels(8'hFF, 11'h7FF);
    write_byte(STORE_BYTES - 1, 8'hFF);
    write_byte(0, 8'h5A);
    read_pixels(0, 0);
    apply_settings(2, 2, 24'h000000, 24'h000000);   // every pixel repeats source pixel 0
    read_pixels(8'hFF, 11'h7FF);
    apply_settings(2048, 16384, 24'h010000, 24'h010000);
    read_pixels(0, 7);
    read_pixels(8'hFF, 0);
    read_pixels(0, 8);          // address past the end of the store
    apply_settings(0, 1, 24'h010000, 24'h010000);   // zero stride
    read_pixels(0, 0);
    apply_settings(4, 0, 24'h010000, 24'h010000);   // zero rows
    read_pixels(0, 0);
    apply_settings(4, 4, 24'hFFFFFF, 24'hFFFFFF);
    read_pixels(0, 0);
    read_pixels(3, 1);

    budget = (ITEM_GOAL - items_sent) / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      if (p < 6)
        apply_settings(fixed_stride[p], fixed_rows[p], fixed_rx[p], fixed_ry[p]);
      else
        apply_settings(STRIDE_W'($urandom_range(1, 64)), ROWS_W'($urandom_range(1, 256)),
                       RATIO_W'($urandom_range(0, 24'h030000)),
                       RATIO_W'($urandom_range(0, 24'h030000)));
      tx_gaps = (p % 3 != 1);
      rx_stalls <= (p % 3 != 1);

      // largest destination coordinates that still land inside the source
      if (cur_rows == 0) row_lim = 0;
      else if (cur_ry == 0) row_lim = MAX_DST_ROWS - 1;
      else row_lim = (longint'(cur_rows) * 65536 - 1) / cur_ry;
      if (row_lim > MAX_DST_ROWS - 1) row_lim = MAX_DST_ROWS - 1;
      if (cur_stride == 0) col_lim = 0;
      else if (cur_rx == 0) col_lim = 255;
      else col_lim = (longint'(cur_stride) * 8 * 65536 - 1) / cur_rx / 8;
      if (col_lim > 255) col_lim = 255;

      start  = items_sent;
      paused = 1'b0;
      while (items_sent - start < budget) begin
        if (p % 2 == 1 && !paused && items_sent - start >= budget / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          write_byte($urandom_range(0, STORE_BYTES - 1), 8'($urandom_range(0, 255)));
        end else begin
          if (roll < 85) begin
            col = 8'($urandom_range(0, int'(col_lim)));
            if ($urandom_range(0, 9) < 4)
              row = 11'($urandom_range(0, (row_lim < 15) ? int'(row_lim) : 15));
            else
              row = 11'($urandom_range(0, int'(row_lim)));
          end else begin
            col = 8'($urandom_range(0, 255));
            row = 11'($urandom_range(0, MAX_DST_ROWS - 1));
          end
          read_pixels(col, row);
        end
      end
    end

    wait_idle();
    $display("%0d transactions sent, %0d of them destination byte reads, over %0d settings",
             items_sent, reads_sent, settings_used);
    $display("%0d result mismatches", failures);
    if (failures == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: binary_image_nearest_scaler.f
design/bins_pkg.sv
design/bins_mul.sv
design/bins_store.sv
design/binary_image_nearest_scaler.sv
tb/sv/scaled_pixel_checker.sv
tb/sv/binary_image_nearest_scaler_test.sv
